[hdl/diff_drive_window_velocity_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the window velocity block
// Shared forms of the concurrent checks, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_WINDOW_VELOCITY_TOP_DEFINES_SVH
`define DIFF_DRIVE_WINDOW_VELOCITY_TOP_DEFINES_SVH

// Same-cycle implication
`define DDWV_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ddwv: same-cycle check failed");

// Next-cycle implication
`define DDWV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ddwv: next-cycle check failed");

`endif

[hdl/ddwv_pkg.sv]
// ----------------------------------------------------------------------------
// ddwv_pkg
// Widths, reset values and constants of the window velocity block.
// ----------------------------------------------------------------------------
package ddwv_pkg;

    // Window and field sizes
    localparam int DDWV_WINDOW_DEPTH = 16;
    localparam int FIELD_W           = 32;
    localparam int CFG_W             = 32;
    localparam int PADDR_W           = 3;

    // Register indexes (paddr bit 2)
    localparam logic REG_WHEEL_DIAMETER = 1'b0;
    localparam logic REG_TRACK_WIDTH    = 1'b1;

    localparam logic [CFG_W-1:0] WHEEL_DIAMETER_RST = 32'd16384;
    localparam logic [CFG_W-1:0] TRACK_WIDTH_RST    = 32'd32768;

    // Microseconds to seconds
    localparam logic [CFG_W-1:0] MICRO_SCALE = 32'd1000000;

    // Datapath widths
    localparam int DIFF_W     = 34;                   // signed angle sums/differences
    localparam int MUL_A_W    = 34;
    localparam int MUL_B_W    = 32;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int SCALED_W   = 54;                   // |s| * 1e6
    localparam int SPLIT_W    = SCALED_W / 2;
    localparam int PART_W     = SPLIT_W + CFG_W;      // one partial product
    localparam int NUM_W      = PART_W + SPLIT_W;     // full numerator
    localparam int DEN_W      = 66;                   // 2 * dt * track_width
    localparam int QUO_W      = 33;                   // quotient bits incl. overflow bit
    localparam int REM_W      = DEN_W + QUO_W - 1;
    localparam int RND_W      = QUO_W + 1;
    localparam int CNT_W      = $clog2(QUO_W);
    localparam int FDEN_SHIFT = 18;

    // Saturation limits by sign of the numerator
    localparam logic [FIELD_W-1:0] LIMIT_POS = 32'h7FFF_FFFF;
    localparam logic [FIELD_W-1:0] LIMIT_NEG = 32'h8000_0000;

endpackage

[hdl/ddwv_if.sv]
// ----------------------------------------------------------------------------
// ddwv_in_if / ddwv_out_if
// Valid/ready stream channels for encoder samples and velocity results.
// ----------------------------------------------------------------------------
interface ddwv_in_if import ddwv_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] sample_time;
    logic [FIELD_W-1:0] left_angle;
    logic [FIELD_W-1:0] right_angle;

    modport source (output valid, output sample_time, output left_angle,
                    output right_angle, input ready);
    modport sink   (input valid, input sample_time, input left_angle,
                    input right_angle, output ready);
endinterface

interface ddwv_out_if import ddwv_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] result_time;
    logic [FIELD_W-1:0] forward_velocity;
    logic [FIELD_W-1:0] yaw_rate;
    logic               span_invalid;
    logic               saturated;

    modport source (output valid, output result_time, output forward_velocity,
                    output yaw_rate, output span_invalid, output saturated,
                    input ready);
    modport sink   (input valid, input result_time, input forward_velocity,
                    input yaw_rate, input span_invalid, input saturated,
                    output ready);
endinterface

[hdl/ddwv_mul.sv]
// ----------------------------------------------------------------------------
// ddwv_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module ddwv_mul import ddwv_pkg::*; (
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [MUL_P_W-1:0] o_p
);

    logic [MUL_P_W-1:0] r_p;

    // Product register
    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

[hdl/ddwv_div.sv]
// ----------------------------------------------------------------------------
// ddwv_div
// Restoring divider, one quotient bit a cycle, rounded half up on magnitude.
// The top quotient bit flags a quotient of 2^32 or more (also zero divisor).
// ----------------------------------------------------------------------------
module ddwv_div import ddwv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [RND_W-1:0] o_quo
);

    typedef enum logic [2:0] {
        D_IDLE  = 3'b001,
        D_STEP  = 3'b010,
        D_ROUND = 3'b100
    } t_div_state;

    t_div_state         r_state, n_state;
    logic [REM_W-1:0]   r_rem;
    logic [REM_W-1:0]   r_dvs;
    logic [DEN_W-1:0]   r_den;
    logic [QUO_W-1:0]   r_q;
    logic [CNT_W-1:0]   r_cnt;
    logic [RND_W-1:0]   r_quo;
    logic               r_done;
    logic [REM_W:0]     w_diff;
    logic               w_ge;
    logic               w_round;

    // Trial subtract: one wide subtract per cycle
    assign w_diff  = {1'b0, r_rem} - {1'b0, r_dvs};
    assign w_ge    = !w_diff[REM_W];
    // Remainder is below the divisor unless the quotient already overflowed
    assign w_round = {r_rem[DEN_W-1:0], 1'b0} >= {1'b0, r_den};

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE:  if (i_start) n_state = D_STEP;
            D_STEP:  if (r_cnt == '0) n_state = D_ROUND;
            D_ROUND: n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == D_ROUND);
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_rem <= REM_W'(i_num);
                    r_dvs <= {i_den, {(QUO_W-1){1'b0}}};
                    r_den <= i_den;
                    r_q   <= '0;
                    r_cnt <= CNT_W'(QUO_W - 1);
                end
            end
            D_STEP: begin
                if (w_ge) r_rem <= w_diff[REM_W-1:0];
                r_q   <= {r_q[QUO_W-2:0], w_ge};
                r_dvs <= r_dvs >> 1;
                r_cnt <= r_cnt - 1'b1;
            end
            D_ROUND: begin
                r_quo <= {1'b0, r_q} + RND_W'(w_round);
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[hdl/diff_drive_window_velocity_top.sv]
// ----------------------------------------------------------------------------
// diff_drive_window_velocity_top
// Wheel odometry velocity from the newest and oldest encoder samples of a
// sliding window: forward velocity and yaw rate, Q16.16, saturated.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake           | payload
//  i_in      | in  | valid/ready         | sample_time, left_angle, right_angle
//  o_out     | out | valid/ready         | result_time, forward_velocity,
//            |     |                     | yaw_rate, span_invalid, saturated
//  APB       | in  | psel/penable/pwrite | paddr, pwdata, prdata (pready = 1)
//
//  One request runs from accept to result: read, difference and the yaw divisor
//  product, then per velocity three multiplier passes, an add, a divider start,
//  33 divider bit steps, round and done, then the output load. A zero time span
//  goes from difference to output; a request that leaves fewer than two samples
//  gives no result. A request is taken only while idle, so an unread result
//  stalls the load and with it the next request. Reset is synchronous, active
//  low; the sample ring itself is not cleared.
// ----------------------------------------------------------------------------
module diff_drive_window_velocity_top import ddwv_pkg::*; #(
    parameter int WINDOW_DEPTH = DDWV_WINDOW_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ddwv_in_if.sink            i_in,
    ddwv_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]   pwdata,
    output logic [CFG_W-1:0]   prdata,
    output logic               pready
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int EW = 3 * FIELD_W;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_READ   = 11'b000_0000_0010,
        S_DIFF   = 11'b000_0000_0100,
        S_TMUL   = 11'b000_0000_1000,
        S_MAG    = 11'b000_0001_0000,
        S_MLO    = 11'b000_0010_0000,
        S_MHI    = 11'b000_0100_0000,
        S_ADD    = 11'b000_1000_0000,
        S_DSTART = 11'b001_0000_0000,
        S_DWAIT  = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } t_state;

    t_state                    r_state, n_state;
    logic [EW-1:0]             r_mem [WINDOW_DEPTH];
    logic [EW-1:0]             r_rd;
    logic [AW-1:0]             r_ws;
    logic [CW-1:0]             r_fill;
    logic [CFG_W-1:0]          r_cfg_d;
    logic [CFG_W-1:0]          r_cfg_t;
    logic [FIELD_W-1:0]        r_t_new;
    logic signed [FIELD_W-1:0] r_l_new;
    logic signed [FIELD_W-1:0] r_r_new;
    logic [FIELD_W-1:0]        r_dt;
    logic signed [DIFF_W-1:0]  r_sf;
    logic signed [DIFF_W-1:0]  r_sy;
    logic [DEN_W-1:0]          r_yden;
    logic [SCALED_W-1:0]       r_a;
    logic [PART_W-1:0]         r_pl;
    logic [NUM_W-1:0]          r_num;
    logic                      r_sel;
    logic [FIELD_W-1:0]        r_fwd;
    logic [FIELD_W-1:0]        r_yaw;
    logic                      r_sat;
    logic                      r_inv;
    logic                      r_o_valid;
    logic [FIELD_W-1:0]        r_o_time;
    logic [FIELD_W-1:0]        r_o_fwd;
    logic [FIELD_W-1:0]        r_o_yaw;
    logic                      r_o_inv;
    logic                      r_o_sat;

    logic                      w_in_acc;
    logic                      w_out_free;
    logic                      w_cfg_wr;
    logic [CW-1:0]             w_fill_inc;
    logic [AW-1:0]             w_ws_inc;
    logic [CW:0]               w_ws_x;
    logic [CW:0]               w_fill_x;
    logic [CW:0]               w_old_x;
    logic [AW-1:0]             w_oldest;
    logic [FIELD_W-1:0]        w_old_t;
    logic signed [FIELD_W-1:0] w_old_l;
    logic signed [FIELD_W-1:0] w_old_r;
    logic [FIELD_W-1:0]        w_dt;
    logic signed [DIFF_W-1:0]  w_dl;
    logic signed [DIFF_W-1:0]  w_dr;
    logic signed [DIFF_W-1:0]  w_s;
    logic                      w_neg;
    logic [DIFF_W-1:0]         w_mag;
    logic [MUL_A_W-1:0]        w_mul_a;
    logic [MUL_B_W-1:0]        w_mul_b;
    logic [MUL_P_W-1:0]        w_mul_p;
    logic [DEN_W-1:0]          w_den;
    logic                      w_div_done;
    logic [RND_W-1:0]          w_quo;
    logic [RND_W-1:0]          w_limit;
    logic                      w_num_zero;
    logic                      w_over;
    logic [FIELD_W-1:0]        w_vmag;
    logic [FIELD_W-1:0]        w_vel;

    // Handshakes
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_out_free = !r_o_valid || o_out.ready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;

    // Configuration registers
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_TRACK_WIDTH) ? r_cfg_t : r_cfg_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_d <= WHEEL_DIAMETER_RST;
            r_cfg_t <= TRACK_WIDTH_RST;
        end else if (w_cfg_wr) begin
            case (paddr[PADDR_W-1])
                REG_WHEEL_DIAMETER: r_cfg_d <= pwdata;
                REG_TRACK_WIDTH:    r_cfg_t <= pwdata;
                default: ;
            endcase
        end
    end

    // Ring pointers; oldest = (write slot - fill) mod depth
    assign w_ws_inc   = (r_ws == AW'(WINDOW_DEPTH - 1)) ? '0 : r_ws + 1'b1;
    assign w_fill_inc = (r_fill < CW'(WINDOW_DEPTH)) ? r_fill + 1'b1 : r_fill;
    assign w_ws_x     = (CW+1)'(r_ws);
    assign w_fill_x   = (CW+1)'(r_fill);
    assign w_old_x    = (w_ws_x >= w_fill_x) ? w_ws_x - w_fill_x
                                             : w_ws_x + (CW+1)'(WINDOW_DEPTH) - w_fill_x;
    assign w_oldest   = w_old_x[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws   <= '0;
            r_fill <= '0;
        end else if (w_in_acc) begin
            r_ws   <= w_ws_inc;
            r_fill <= w_fill_inc;
        end
    end

    // Sample ring: written on accept, oldest entry read in S_READ
    always_ff @(posedge i_clk) begin
        if (w_in_acc) r_mem[r_ws] <= {i_in.sample_time, i_in.left_angle, i_in.right_angle};
        if (r_state == S_READ) r_rd <= r_mem[w_oldest];
    end

    // Window differences
    assign w_old_t = r_rd[EW-1:2*FIELD_W];
    assign w_old_l = r_rd[2*FIELD_W-1:FIELD_W];
    assign w_old_r = r_rd[FIELD_W-1:0];
    assign w_dt    = r_t_new - w_old_t;
    assign w_dl    = DIFF_W'(r_l_new) - DIFF_W'(w_old_l);
    assign w_dr    = DIFF_W'(r_r_new) - DIFF_W'(w_old_r);

    // Signed numerator of the velocity in progress
    assign w_s   = r_sel ? r_sy : r_sf;
    assign w_neg = w_s[DIFF_W-1];
    assign w_mag = w_neg ? $unsigned(-w_s) : $unsigned(w_s);

    // Shared multiplier operands
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_TMUL: begin
                w_mul_a = MUL_A_W'(r_dt);
                w_mul_b = r_cfg_t;
            end
            S_MAG: begin
                w_mul_a = w_mag;
                w_mul_b = MICRO_SCALE;
            end
            S_MLO: begin
                w_mul_a = MUL_A_W'(w_mul_p[SPLIT_W-1:0]);
                w_mul_b = r_cfg_d;
            end
            S_MHI: begin
                w_mul_a = MUL_A_W'(r_a[SCALED_W-1:SPLIT_W]);
                w_mul_b = r_cfg_d;
            end
            default: ;
        endcase
    end

    ddwv_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    // Divisor: dt << 18 for forward, 2 * dt * track_width for yaw
    assign w_den = r_sel ? r_yden : DEN_W'({r_dt, {FDEN_SHIFT{1'b0}}});

    ddwv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DSTART),
        .i_num   (r_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Saturate and apply sign
    assign w_limit    = w_neg ? RND_W'(LIMIT_NEG) : RND_W'(LIMIT_POS);
    assign w_num_zero = (r_num == '0);
    assign w_over     = (w_quo > w_limit) && !w_num_zero;
    assign w_vmag     = w_num_zero ? '0 : (w_over ? w_limit[FIELD_W-1:0] : w_quo[FIELD_W-1:0]);
    assign w_vel      = w_neg ? FIELD_W'(0) - w_vmag : w_vmag;

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_in_acc && w_fill_inc >= CW'(2)) n_state = S_READ;
            S_READ:   n_state = S_DIFF;
            S_DIFF:   n_state = (w_dt == '0) ? S_OUT : S_TMUL;
            S_TMUL:   n_state = S_MAG;
            S_MAG:    n_state = S_MLO;
            S_MLO:    n_state = S_MHI;
            S_MHI:    n_state = S_ADD;
            S_ADD:    n_state = S_DSTART;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT:  if (w_div_done) n_state = r_sel ? S_OUT : S_MAG;
            S_OUT:    if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_t_new <= i_in.sample_time;
                    r_l_new <= i_in.left_angle;
                    r_r_new <= i_in.right_angle;
                end
            end
            S_DIFF: begin
                r_dt  <= w_dt;
                r_sf  <= w_dl - w_dr;
                r_sy  <= DIFF_W'(0) - (w_dl + w_dr);
                r_sel <= 1'b0;
                r_fwd <= '0;
                r_yaw <= '0;
                r_sat <= 1'b0;
                r_inv <= (w_dt == '0);
            end
            S_MAG: begin
                // product of S_TMUL is on the multiplier output here
                if (!r_sel) r_yden <= {w_mul_p[DEN_W-2:0], 1'b0};
            end
            S_MLO: r_a  <= w_mul_p[SCALED_W-1:0];
            S_MHI: r_pl <= w_mul_p[PART_W-1:0];
            S_ADD: r_num <= {w_mul_p[PART_W-1:0], {SPLIT_W{1'b0}}} + NUM_W'(r_pl);
            S_DWAIT: begin
                if (w_div_done) begin
                    if (r_sel) r_yaw <= w_vel;
                    else       r_fwd <= w_vel;
                    r_sat <= r_sat | w_over;
                    r_sel <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Output register: load wins over the clear of a taken result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_o_time <= r_t_new;
            r_o_fwd  <= r_fwd;
            r_o_yaw  <= r_yaw;
            r_o_inv  <= r_inv;
            r_o_sat  <= r_sat;
        end
    end

    assign o_out.valid            = r_o_valid;
    assign o_out.result_time      = r_o_time;
    assign o_out.forward_velocity = r_o_fwd;
    assign o_out.yaw_rate         = r_o_yaw;
    assign o_out.span_invalid     = r_o_inv;
    assign o_out.saturated        = r_o_sat;

endmodule

[hdl/ddwv_chk.sv]
// ----------------------------------------------------------------------------
// ddwv_chk
// Port-level checks of the window velocity block, bound to the top level.
// ----------------------------------------------------------------------------
`include "diff_drive_window_velocity_top_defines.svh"

module ddwv_chk import ddwv_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [FIELD_W-1:0] i_fwd,
    input logic [FIELD_W-1:0] i_yaw,
    input logic               i_inv,
    input logic               i_sat
);

    // A stalled result keeps its velocities
    `DDWV_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_fwd) && $stable(i_yaw))

    // Zero time span gives zero velocities and no clipping
    `DDWV_ASSERT_IMPL(a_span_zero, i_out_valid && i_inv, i_fwd == '0 && i_yaw == '0 && !i_sat)

    // A result never shows up right after a request is taken
    `DDWV_ASSERT_NEXT(a_no_fast_result, i_in_valid && i_in_ready, !$rose(i_out_valid))

    // A result is loaded only while the block is busy
    `DDWV_ASSERT_IMPL(a_load_while_busy, $rose(i_out_valid), !$past(i_in_ready))

endmodule

bind diff_drive_window_velocity_top ddwv_chk u_ddwv_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_fwd       (o_out.forward_velocity),
    .i_yaw       (o_out.yaw_rate),
    .i_inv       (o_out.span_invalid),
    .i_sat       (o_out.saturated)
);
